FILE: rtl/core/apt_pkg.sv
// apt_pkg: shared types and constants for the animation progress timeline
// used by the top level, the divider step unit and the port checker
package apt_pkg;

   // fixed field widths
   localparam int DUR_W  = 24;
   localparam int CNT_W  = 16;
   localparam int PLEN_W = DUR_W + 1;
   localparam int REM_W  = PLEN_W;
   localparam int LIM_W  = CNT_W + PLEN_W;
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_PREP     = 6'b000010,
      ST_DIV_PASS = 6'b000100,
      ST_CHECK    = 6'b001000,
      ST_DIV_RAMP = 6'b010000,
      ST_RESULT   = 6'b100000
   } seq_state_type;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_PLAY  = 2'd1,
      REQ_PAUSE = 2'd2,
      REQ_STOP  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      RUN_STOPPED = 2'd0,
      RUN_PLAYING = 2'd1,
      RUN_PAUSED  = 2'd2
   } run_state_type;

   typedef enum logic [2:0] {
      CSR_DURATION   = 3'd0,
      CSR_START_WAIT = 3'd1,
      CSR_LOOP_GAP   = 3'd2,
      CSR_LOOP_COUNT = 3'd3,
      CSR_FOREVER    = 3'd4,
      CSR_LOOP_MODE  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic             ge;
      logic [REM_W-1:0] rem;
   } apt_step_type;

endpackage

FILE: rtl/core/apt_div_step.sv
// apt_div_step: one restoring division step, shared by the pass and ramp divisions
// depends on apt_pkg
module apt_div_step (
   input  logic [apt_pkg::REM_W-1:0] rem,
   input  logic                      shift_bit,
   input  logic [apt_pkg::REM_W-1:0] divisor,
   output apt_pkg::apt_step_type     step_out
);
   import apt_pkg::*;

   logic [REM_W:0]   trial;
   logic [REM_W+1:0] diff;

   assign trial = {rem, shift_bit};
   assign diff  = {1'b0, trial} - {2'b00, divisor};

   // remainder stays below the divisor, so it always fits back in REM_W bits
   assign step_out.ge  = ~diff[REM_W+1];
   assign step_out.rem = step_out.ge ? diff[REM_W-1:0] : trial[REM_W-1:0];

endmodule

FILE: rtl/core/animation_progress_timeline.sv
// animation_progress_timeline: event-driven animation timeline with Q fraction output
// depends on apt_pkg and apt_div_step
//
// channel  dir  handshake               payload
// req      in   req_tvalid/req_tready   tuser: event kind, tdata: now_ms
// rsp      out  rsp_tvalid/rsp_tready   tdata: progress, flags, run state, pass
// csr      in   apb, pready always high 6 registers at byte address 4*i
//
// one shared subtract/compare unit runs the pass division a bit a cycle, then the ramp
// division, skipped once the ramp saturates or the run is past its last pass; a frame
// with zero pass length skips both and goes from the difference through a check step
// to the result; a word that makes no frame steps through accept, difference, result
// reset is synchronous, no clearing pass
// a stalled result holds the output register; the next word then waits in the result step
module animation_progress_timeline #(
   parameter int TIME_BITS     = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,   // [31:0] now_ms
   input  logic [1:0]                          req_tuser,   // [1:0] req_type
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // progress, frame_valid, run_state_out, loop_index, finished, zero fill
   output logic [((FRACTION_BITS+21+7)/8)*8-1:0] rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [apt_pkg::CSR_AW-1:0]          csr_paddr,
   input  logic [apt_pkg::CSR_DW-1:0]          csr_pwdata,
   output logic [apt_pkg::CSR_DW-1:0]          csr_prdata,
   output logic                                csr_pready
);
   import apt_pkg::*;

   localparam int TB    = TIME_BITS;
   localparam int FB    = FRACTION_BITS;
   localparam int PW    = FB + 1;
   localparam int RSP_W = ((FB + 21 + 7) / 8) * 8;
   localparam int QW    = (TB > FB) ? TB : FB;
   localparam int CW    = $clog2(QW);
   localparam int CMPW  = (TB > LIM_W) ? TB : LIM_W;
   localparam logic [PW-1:0] ONE_Q = {1'b1, {FB{1'b0}}};

   // configuration
   logic [DUR_W-1:0] dur_ff, dur_in, sw_ff, sw_in, gap_ff, gap_in;
   logic [CNT_W-1:0] lc_ff, lc_in;
   logic             forever_ff, forever_in, mode_ff, mode_in;

   // sequencer and timeline state
   seq_state_type    state_ff, state_in;
   run_state_type    run_ff, run_in;
   req_kind_type     kind_ff, kind_in;
   logic [TB-1:0]    now_ff, now_in, st_ff, st_in, pt_ff, pt_in, pb_ff, pb_in;
   logic [CNT_W-1:0] pass_cnt_ff, pass_cnt_in;

   // working registers
   logic [TB-1:0]    t_ff, t_in, pass_ff, pass_in;
   logic [QW-1:0]    q_ff, q_in;
   logic [REM_W-1:0] r_ff, r_in, div_ff, div_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [LIM_W-1:0] lim_ff, lim_in;
   logic             frame_ff, frame_in, past_ff, past_in, ramp_one_ff, ramp_one_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic [PLEN_W-1:0] plen;
   logic [TB-1:0]     t_calc;
   logic              shift_bit;
   apt_step_type      step;
   logic [PW-1:0]     ramp_v, prog_c;
   logic              valid_c, fin_c, past_c, ramp_one_c;
   logic [CNT_W-1:0]  pass_sat;
   logic              csr_wr;

   assign plen   = {1'b0, dur_ff} + {1'b0, gap_ff};
   assign t_calc = now_ff - TB'(sw_ff) - pt_ff - st_ff;

   assign shift_bit = (state_ff == ST_DIV_PASS) ? q_ff[QW-1] : 1'b0;

   apt_div_step u_step (
      .rem       (r_ff),
      .shift_bit (shift_bit),
      .divisor   (div_ff),
      .step_out  (step)
   );

   assign past_c     = ~forever_ff && (q_ff[TB-1:0] >= TB'(lc_ff));
   assign ramp_one_c = (dur_ff == '0) || (r_ff >= REM_W'(dur_ff));
   assign ramp_v     = ramp_one_ff ? ONE_Q : PW'(q_ff[FB-1:0]);
   assign pass_sat   = (pass_ff > TB'({CNT_W{1'b1}})) ? {CNT_W{1'b1}} : pass_ff[CNT_W-1:0];

   // frame value for a tick while playing
   always_comb begin
      if (plen == '0) begin
         prog_c = ONE_Q;
      end else if (!mode_ff) begin
         prog_c = past_ff ? ONE_Q : ramp_v;
      end else if (past_ff) begin
         prog_c = lc_ff[0] ? ONE_Q : '0;
      end else if (!pass_ff[0]) begin
         prog_c = ramp_v;
      end else begin
         prog_c = ONE_Q - ramp_v;
      end
   end

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      dur_in     = dur_ff;
      sw_in      = sw_ff;
      gap_in     = gap_ff;
      lc_in      = lc_ff;
      forever_in = forever_ff;
      mode_in    = mode_ff;
      if (csr_wr) begin
         unique case (csr_index_type'(csr_paddr[4:2]))
            CSR_DURATION:   dur_in     = csr_pwdata[DUR_W-1:0];
            CSR_START_WAIT: sw_in      = csr_pwdata[DUR_W-1:0];
            CSR_LOOP_GAP:   gap_in     = csr_pwdata[DUR_W-1:0];
            CSR_LOOP_COUNT: lc_in      = csr_pwdata[CNT_W-1:0];
            CSR_FOREVER:    forever_in = csr_pwdata[0];
            CSR_LOOP_MODE:  mode_in    = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index_type'(csr_paddr[4:2]))
         CSR_DURATION:   csr_prdata = CSR_DW'(dur_ff);
         CSR_START_WAIT: csr_prdata = CSR_DW'(sw_ff);
         CSR_LOOP_GAP:   csr_prdata = CSR_DW'(gap_ff);
         CSR_LOOP_COUNT: csr_prdata = CSR_DW'(lc_ff);
         CSR_FOREVER:    csr_prdata = CSR_DW'(forever_ff);
         CSR_LOOP_MODE:  csr_prdata = CSR_DW'(mode_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      run_in       = run_ff;
      kind_in      = kind_ff;
      now_in       = now_ff;
      st_in        = st_ff;
      pt_in        = pt_ff;
      pb_in        = pb_ff;
      pass_cnt_in  = pass_cnt_ff;
      t_in         = t_ff;
      pass_in      = pass_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      div_in       = div_ff;
      cnt_in       = cnt_ff;
      lim_in       = lim_ff;
      frame_in     = frame_ff;
      past_in      = past_ff;
      ramp_one_in  = ramp_one_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      valid_c      = 1'b0;
      fin_c        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_kind_type'(req_tuser);
               now_in   = TB'(req_tdata);
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            t_in     = t_calc;
            frame_in = (kind_ff == REQ_TICK) && (run_ff == RUN_PLAYING) && ~t_calc[TB-1];
            cnt_in   = '0;
            div_in   = plen;
            r_in     = '0;
            if (!frame_in) begin
               state_in = ST_RESULT;
            end else if (plen == '0) begin
               q_in     = '0;
               state_in = ST_CHECK;
            end else begin
               // dividend left-aligned, quotient bits enter at the bottom
               q_in     = QW'(t_calc) << (QW - TB);
               state_in = ST_DIV_PASS;
            end
         end
         ST_DIV_PASS: begin
            r_in   = step.rem;
            q_in   = {q_ff[QW-2:0], step.ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(TB - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            pass_in     = q_ff[TB-1:0];
            past_in     = past_c;
            ramp_one_in = ramp_one_c;
            lim_in      = LIM_W'(lc_ff) * LIM_W'(plen);
            cnt_in      = '0;
            if ((plen != '0) && !past_c && !ramp_one_c) begin
               q_in     = '0;
               div_in   = REM_W'(dur_ff);
               state_in = ST_DIV_RAMP;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_DIV_RAMP: begin
            r_in   = step.rem;
            q_in   = {q_ff[QW-2:0], step.ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(FB - 1)) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               unique case (kind_ff)
                  REQ_TICK: begin
                     if (run_ff == RUN_STOPPED) begin
                        st_in = now_ff;
                     end else if (frame_ff) begin
                        valid_c     = 1'b1;
                        pass_cnt_in = pass_sat;
                        if (!forever_ff && (CMPW'(t_ff) > CMPW'(lim_ff))) begin
                           run_in = RUN_STOPPED;
                           pt_in  = '0;
                           fin_c  = 1'b1;
                        end
                     end
                  end
                  REQ_PLAY: begin
                     if (run_ff == RUN_PAUSED) begin
                        pt_in  = pt_ff + now_ff - pb_ff;
                        run_in = RUN_PLAYING;
                     end else if (run_ff == RUN_STOPPED) begin
                        run_in = RUN_PLAYING;
                     end
                  end
                  REQ_PAUSE: begin
                     run_in = RUN_PAUSED;
                     pb_in  = now_ff;
                  end
                  REQ_STOP: begin
                     run_in = RUN_STOPPED;
                     pt_in  = '0;
                  end
                  default: ;
               endcase
               rsp_data_in  = RSP_W'({fin_c, pass_cnt_in, run_in, valid_c,
                                      valid_c ? prog_c : {PW{1'b0}}});
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dur_ff       <= '0;
         sw_ff        <= '0;
         gap_ff       <= '0;
         lc_ff        <= CNT_W'(1);
         forever_ff   <= 1'b0;
         mode_ff      <= 1'b0;
         state_ff     <= ST_IDLE;
         run_ff       <= RUN_STOPPED;
         st_ff        <= '0;
         pt_ff        <= '0;
         pb_ff        <= '0;
         pass_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dur_ff       <= dur_in;
         sw_ff        <= sw_in;
         gap_ff       <= gap_in;
         lc_ff        <= lc_in;
         forever_ff   <= forever_in;
         mode_ff      <= mode_in;
         state_ff     <= state_in;
         run_ff       <= run_in;
         st_ff        <= st_in;
         pt_ff        <= pt_in;
         pb_ff        <= pb_in;
         pass_cnt_ff  <= pass_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      now_ff      <= now_in;
      t_ff        <= t_in;
      pass_ff     <= pass_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      div_ff      <= div_in;
      cnt_ff      <= cnt_in;
      lim_ff      <= lim_in;
      frame_ff    <= frame_in;
      past_ff     <= past_in;
      ramp_one_ff <= ramp_one_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/core/apt_checker.sv
// apt_checker: port-level checks on the animation progress timeline, bound to the top level
// depends on apt_pkg
module apt_checker #(
   parameter int FRACTION_BITS = 16
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [((FRACTION_BITS+21+7)/8)*8-1:0] rsp_tdata
);
   import apt_pkg::*;

   localparam int PW = FRACTION_BITS + 1;
   localparam logic [PW-1:0] ONE_Q = {1'b1, {FRACTION_BITS{1'b0}}};

   logic [PW-1:0] progress;
   logic          frame_valid, finished;
   logic [1:0]    run_state;

   assign progress    = rsp_tdata[PW-1:0];
   assign frame_valid = rsp_tdata[PW];
   assign run_state   = rsp_tdata[PW+2:PW+1];
   assign finished    = rsp_tdata[PW+19];

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // the block is busy in the cycle after it takes a word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready straight after accepting a word");

   a_no_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !frame_valid |-> progress == '0)
      else $error("progress set without a frame");

   a_progress_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> progress <= ONE_Q)
      else $error("progress above one");

   a_finish_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && finished |-> frame_valid && run_state == RUN_STOPPED)
      else $error("finished without a frame or without stopping");

endmodule

bind animation_progress_timeline apt_checker #(.FRACTION_BITS(FRACTION_BITS)) u_apt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
